FILE: design/rocq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocq_pkg
// Shared types and codes for the ROC area penalty unit.
// ----------------------------------------------------------------------------
package rocq_pkg;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_COMPUTE = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    localparam int unsigned FRAC_BITS = 17;
    localparam logic [16:0] PENALTY_ONE = 17'h10000;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_SKIP  = 3'd2,
        ST_CLASS = 3'd3,
        ST_ZERO  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RANK,
        S_SRCH_START,
        S_SRCH_SCAN,
        S_CLS_START,
        S_CLS_SCAN,
        S_MUL,
        S_ACC,
        S_DPREP,
        S_DINIT,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    comp_start;
        logic    set_done;
        logic    code_load;
        status_t code;
        logic    rank_step;
        logic    scan_start;
        logic    scan_class;
        logic    srch_update;
        logic    mul;
        logic    acc;
        logic    dprep;
        logic    dinit;
        logic    div_step;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic store_empty;
        logic skip;
        logic class_empty;
        logic zero_gene;
        logic rank_ready;
        logic bit_zero;
        logic scan_done;
        logic k_last;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

FILE: design/rocq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocq channel interfaces
// Valid/ready channels for request items, result items and configuration.
// ----------------------------------------------------------------------------
interface rocq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] dwell_value;
    logic        is_positive;
    logic        gene_zero_ratio;
    logic        compute_again;

    modport source (output valid, mode, dwell_value, is_positive, gene_zero_ratio,
                    compute_again, input ready);
    modport sink (input valid, mode, dwell_value, is_positive, gene_zero_ratio,
                  compute_again, output ready);
endinterface

interface rocq_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] penalty;
    logic [2:0]  status;
    logic        replace_total;
    logic        overflowed;

    modport source (output valid, penalty, status, replace_total, overflowed,
                    input ready);
    modport sink (input valid, penalty, status, replace_total, overflowed,
                  output ready);
endinterface

interface rocq_cfg_if;
    logic valid;
    logic ready;
    logic pauser_mode;

    modport source (output valid, pauser_mode, input ready);
    modport sink (input valid, pauser_mode, output ready);
endinterface

FILE: design/roc_auc_quantile_thresholds_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roc_auc_quantile_thresholds_unit
// Stores tagged dwell values and returns one minus the ROC area on request.
// ----------------------------------------------------------------------------
// Load items are accepted back to back while the unit is idle. A compute item
// that does the full calculation visits every one of its NUM_THRESHOLDS+1
// thresholds in turn. Each threshold is found by a 32-step bitwise search,
// each step a full pass over the single read port of the value store, then
// one more pass counts each class below it. A compute item that ends early
// goes straight to the emit state, which registers its result once the
// output register is free.
// ----------------------------------------------------------------------------
module roc_auc_quantile_thresholds_unit
    import rocq_pkg::*;
#(
    parameter int MAX_VALUES     = 1024,
    parameter int NUM_THRESHOLDS = 32
) (
    input logic clk,
    input logic rst_n,
    rocq_in_if.sink    req,
    rocq_out_if.source rsp,
    rocq_cfg_if.sink   cfg
);

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    rocq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(req.valid),
        .in_mode (req.mode),
        .in_ready(req.ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rocq_dp #(
        .MAX_VALUES    (MAX_VALUES),
        .NUM_THRESHOLDS(NUM_THRESHOLDS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .dwell_value      (req.dwell_value),
        .is_positive      (req.is_positive),
        .gene_zero_ratio  (req.gene_zero_ratio),
        .compute_again    (req.compute_again),
        .cfg_valid        (cfg.valid),
        .cfg_pauser_mode  (cfg.pauser_mode),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_penalty      (rsp.penalty),
        .out_status       (rsp.status),
        .out_replace_total(rsp.replace_total),
        .out_overflowed   (rsp.overflowed)
    );

endmodule

FILE: design/rocq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rocq_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/rocq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocq_ctrl
// Sequencer that steps the datapath through thresholds, scans and division.
// ----------------------------------------------------------------------------
module rocq_ctrl
    import rocq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_mode,
    output logic       in_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_mode == MODE_COMPUTE)
                begin
                    priority if (sts.store_empty || sts.skip || sts.class_empty
                                 || sts.zero_gene)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_RANK;
                    end
                end
            end
            S_RANK:
            begin
                if (sts.rank_ready)
                begin
                    state_next = S_SRCH_START;
                end
            end
            S_SRCH_START: state_next = S_SRCH_SCAN;
            S_SRCH_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.bit_zero ? S_CLS_START : S_SRCH_START;
                end
            end
            S_CLS_START: state_next = S_CLS_SCAN;
            S_CLS_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_ACC;
            S_ACC: state_next = sts.k_last ? S_DPREP : S_RANK;
            S_DPREP: state_next = S_DINIT;
            S_DINIT: state_next = S_DIV;
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.code = ST_OK;
        in_ready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = (in_mode == MODE_LOAD);
                    cmd.clear = (in_mode == MODE_CLEAR);
                    if (in_mode == MODE_COMPUTE)
                    begin
                        cmd.comp_start = 1'b1;
                        cmd.code_load = 1'b1;
                        priority if (sts.store_empty)
                        begin
                            cmd.code = ST_EMPTY;
                        end
                        else if (sts.skip)
                        begin
                            cmd.code = ST_SKIP;
                        end
                        else if (sts.class_empty)
                        begin
                            cmd.set_done = 1'b1;
                            cmd.code = ST_CLASS;
                        end
                        else if (sts.zero_gene)
                        begin
                            cmd.set_done = 1'b1;
                            cmd.code = ST_ZERO;
                        end
                        else
                        begin
                            cmd.set_done = 1'b1;
                            cmd.code = ST_OK;
                        end
                    end
                end
            end
            S_RANK: cmd.rank_step = 1'b1;
            S_SRCH_START: cmd.scan_start = 1'b1;
            S_SRCH_SCAN: cmd.srch_update = sts.scan_done;
            S_CLS_START:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_class = 1'b1;
            end
            S_CLS_SCAN: ;
            S_MUL: cmd.mul = 1'b1;
            S_ACC: cmd.acc = 1'b1;
            S_DPREP: cmd.dprep = 1'b1;
            S_DINIT: cmd.dinit = 1'b1;
            S_DIV: cmd.div_step = 1'b1;
            S_EMIT: cmd.emit = sts.out_free;
            default: ;
        endcase
    end

endmodule

FILE: design/rocq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rocq_dp
// Value store, counters, threshold search, area sum, divider and result register.
// ----------------------------------------------------------------------------
module rocq_dp
    import rocq_pkg::*;
#(
    parameter int MAX_VALUES     = 1024,
    parameter int NUM_THRESHOLDS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [31:0] dwell_value,
    input  logic        is_positive,
    input  logic        gene_zero_ratio,
    input  logic        compute_again,
    input  logic        cfg_valid,
    input  logic        cfg_pauser_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] out_penalty,
    output logic [2:0]  out_status,
    output logic        out_replace_total,
    output logic        out_overflowed
);

    localparam int AW = $clog2(MAX_VALUES);
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int KW = $clog2(NUM_THRESHOLDS + 1);
    localparam int RW = $clog2(NUM_THRESHOLDS + MAX_VALUES + 1);
    localparam int PW = 2 * CW + 1;
    localparam int SW = 2 * CW + 2;
    localparam int NW = 2 * CW + 19;
    localparam logic [RW-1:0] NT_R = RW'(NUM_THRESHOLDS);
    localparam logic [KW-1:0] NT_K = KW'(NUM_THRESHOLDS);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_VALUES);

    logic [CW-1:0]   pos_cnt_reg, neg_cnt_reg;
    logic            done_flag_reg, zero_seen_reg, ovf_seen_reg, pauser_reg, again_reg;
    status_t         code_reg;
    logic [KW-1:0]   k_reg;
    logic [CW-1:0]   q_reg, rank_reg;
    logic [RW-1:0]   rem_reg;
    logic [31:0]     res_reg;
    logic [4:0]      bit_reg;
    logic            class_mode_reg;
    logic [CW-1:0]   scan_idx_reg;
    logic            scan_on_reg, rd_valid_reg, rd_last_reg, scan_done_reg;
    logic [CW-1:0]   pb_reg, nb_reg, prev_pb_reg, prev_nb_reg;
    logic [PW-1:0]   prod_reg;
    logic [SW-1:0]   s_reg;
    logic [2*CW-1:0] dprod_reg;
    logic [NW-1:0]   num_reg, dv_reg;
    logic [16:0]     quot_reg;
    logic [4:0]      dcnt_reg;
    logic            out_valid_reg;
    logic [16:0]     out_penalty_reg;
    logic [2:0]      out_status_reg;
    logic            out_replace_reg, out_ovf_reg;

    logic [CW-1:0]   total, total_m1, dn;
    logic [CW:0]     below_all, pos_term;
    logic [32:0]     rd_data;
    logic [31:0]     cand, thr;
    logic            store_we, rank_ready;
    logic [PW-1:0]   d_val;
    logic [SW-1:0]   s_clamp;
    logic [16:0]     pen_sel;

    assign total     = pos_cnt_reg + neg_cnt_reg;
    assign total_m1  = total - CW'(1);
    assign store_we  = cmd.load && (total != MAX_C);
    assign cand      = res_reg | (32'd1 << bit_reg);
    assign thr       = class_mode_reg ? res_reg : cand;
    assign below_all = {1'b0, pb_reg} + {1'b0, nb_reg};
    assign dn        = (nb_reg >= prev_nb_reg) ? nb_reg - prev_nb_reg : prev_nb_reg - nb_reg;
    assign pos_term  = {pos_cnt_reg, 1'b0} - {1'b0, prev_pb_reg} - {1'b0, pb_reg};
    assign rank_ready = (k_reg == NT_K) || (rem_reg < NT_R);
    assign d_val     = {dprod_reg, 1'b0};
    assign s_clamp   = (s_reg > SW'(d_val)) ? SW'(d_val) : s_reg;

    always_comb
    begin
        unique case (code_reg)
            ST_OK:              pen_sel = quot_reg;
            ST_CLASS, ST_ZERO:  pen_sel = PENALTY_ONE;
            default:            pen_sel = '0;
        endcase
    end

    rocq_ram #(
        .WIDTH(33),
        .DEPTH(MAX_VALUES)
    ) u_store (
        .clk  (clk),
        .we   (store_we),
        .waddr(total[AW-1:0]),
        .wdata({is_positive, dwell_value}),
        .raddr(scan_idx_reg[AW-1:0]),
        .rdata(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_cnt_reg    <= '0;
            neg_cnt_reg    <= '0;
            done_flag_reg  <= 1'b0;
            zero_seen_reg  <= 1'b0;
            ovf_seen_reg   <= 1'b0;
            pauser_reg     <= 1'b0;
            again_reg      <= 1'b0;
            code_reg       <= ST_OK;
            k_reg          <= '0;
            q_reg          <= '0;
            rank_reg       <= '0;
            rem_reg        <= '0;
            res_reg        <= '0;
            bit_reg        <= '0;
            class_mode_reg <= 1'b0;
            scan_idx_reg   <= '0;
            scan_on_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            scan_done_reg  <= 1'b0;
            pb_reg         <= '0;
            nb_reg         <= '0;
            prev_pb_reg    <= '0;
            prev_nb_reg    <= '0;
            prod_reg       <= '0;
            s_reg          <= '0;
            dprod_reg      <= '0;
            num_reg        <= '0;
            dv_reg         <= '0;
            quot_reg       <= '0;
            dcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pauser_reg <= cfg_pauser_mode;
            end

            if (cmd.load)
            begin
                if (gene_zero_ratio)
                begin
                    zero_seen_reg <= 1'b1;
                end
                if (total == MAX_C)
                begin
                    ovf_seen_reg <= 1'b1;
                end
                else if (is_positive)
                begin
                    pos_cnt_reg <= pos_cnt_reg + CW'(1);
                end
                else
                begin
                    neg_cnt_reg <= neg_cnt_reg + CW'(1);
                end
            end

            if (cmd.clear)
            begin
                pos_cnt_reg   <= '0;
                neg_cnt_reg   <= '0;
                done_flag_reg <= 1'b0;
                zero_seen_reg <= 1'b0;
                ovf_seen_reg  <= 1'b0;
            end

            if (cmd.comp_start)
            begin
                again_reg   <= compute_again;
                k_reg       <= '0;
                q_reg       <= '0;
                rem_reg     <= '0;
                s_reg       <= '0;
                prev_pb_reg <= '0;
                prev_nb_reg <= '0;
            end
            if (cmd.code_load)
            begin
                code_reg <= cmd.code;
            end
            if (cmd.set_done)
            begin
                done_flag_reg <= 1'b1;
            end

            if (cmd.rank_step)
            begin
                if (k_reg == NT_K)
                begin
                    rank_reg <= total_m1;
                end
                else if (rem_reg >= NT_R)
                begin
                    rem_reg <= rem_reg - NT_R;
                    q_reg   <= q_reg + CW'(1);
                end
                else
                begin
                    rank_reg <= q_reg;
                end
                if (rank_ready)
                begin
                    res_reg <= '0;
                    bit_reg <= 5'd31;
                end
            end

            if (cmd.scan_start)
            begin
                scan_idx_reg   <= '0;
                scan_on_reg    <= 1'b1;
                pb_reg         <= '0;
                nb_reg         <= '0;
                class_mode_reg <= cmd.scan_class;
            end
            else if (scan_on_reg)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
                if (scan_idx_reg == total_m1)
                begin
                    scan_on_reg <= 1'b0;
                end
            end
            rd_valid_reg  <= scan_on_reg && !cmd.scan_start;
            rd_last_reg   <= scan_on_reg && !cmd.scan_start && (scan_idx_reg == total_m1);
            scan_done_reg <= rd_valid_reg && rd_last_reg;
            if (rd_valid_reg && (rd_data[31:0] < thr))
            begin
                if (rd_data[32])
                begin
                    pb_reg <= pb_reg + CW'(1);
                end
                else
                begin
                    nb_reg <= nb_reg + CW'(1);
                end
            end

            if (cmd.srch_update)
            begin
                if (below_all <= {1'b0, rank_reg})
                begin
                    res_reg <= cand;
                end
                bit_reg <= bit_reg - 5'd1;
            end

            if (cmd.mul)
            begin
                prod_reg <= PW'(dn) * PW'(pos_term);
            end

            if (cmd.acc)
            begin
                if (k_reg != '0)
                begin
                    s_reg <= s_reg + SW'(prod_reg);
                end
                prev_pb_reg <= pb_reg;
                prev_nb_reg <= nb_reg;
                k_reg       <= k_reg + KW'(1);
                rem_reg     <= rem_reg + RW'(total);
            end

            if (cmd.dprep)
            begin
                dprod_reg <= (2 * CW)'(neg_cnt_reg) * (2 * CW)'(pos_cnt_reg);
            end

            if (cmd.dinit)
            begin
                num_reg  <= (NW'(SW'(d_val) - s_clamp) << FRAC_BITS) + NW'(d_val);
                dv_reg   <= NW'(d_val) << FRAC_BITS;
                quot_reg <= '0;
                dcnt_reg <= 5'd16;
            end

            if (cmd.div_step)
            begin
                if (num_reg >= dv_reg)
                begin
                    num_reg  <= num_reg - dv_reg;
                    quot_reg <= {quot_reg[15:0], 1'b1};
                end
                else
                begin
                    quot_reg <= {quot_reg[15:0], 1'b0};
                end
                dv_reg   <= dv_reg >> 1;
                dcnt_reg <= dcnt_reg - 5'd1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_penalty_reg <= pen_sel;
            out_status_reg  <= code_reg;
            out_replace_reg <= (code_reg == ST_OK) && again_reg;
            out_ovf_reg     <= ovf_seen_reg;
        end
    end

    assign sts.store_empty = (total == '0);
    assign sts.skip        = done_flag_reg && !compute_again;
    assign sts.class_empty = (pos_cnt_reg == '0) || (neg_cnt_reg == '0);
    assign sts.zero_gene   = !pauser_reg && zero_seen_reg;
    assign sts.rank_ready  = rank_ready;
    assign sts.bit_zero    = (bit_reg == 5'd0);
    assign sts.scan_done   = scan_done_reg;
    assign sts.k_last      = (k_reg == NT_K);
    assign sts.div_last    = (dcnt_reg == 5'd0);
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign out_penalty       = out_penalty_reg;
    assign out_status        = out_status_reg;
    assign out_replace_total = out_replace_reg;
    assign out_overflowed    = out_ovf_reg;

endmodule
